### hdl/pfd_pkg.sv
// Package: constants and state type for the positioning frame decoder.
package pfd_pkg;

   localparam int FRAME_BYTES_DEF = 128;

   localparam logic [7:0] HDR0 = 8'h55;
   localparam logic [7:0] HDR1 = 8'h01;

   localparam int STORE_FIRST = 4;
   localparam int STORE_LAST  = 69;
   localparam int STORE_DEPTH = STORE_LAST - STORE_FIRST + 1;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam int NUM_FIELDS  = 26;
   localparam int WIDE_FIELDS = 14;
   localparam int FIELD_W     = 5;
   localparam int VALUE_W     = 24;
   localparam int COUNT_W     = 32;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_HDR1,
      ST_BODY,
      ST_READ,
      ST_WAIT
   } state_type;

endpackage

### hdl/positioning_frame_decoder_unit.sv
// Top level: positioning sensor frame decoder (header hunt, checksum, field readout).
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------------
//  req     | in  | req_valid/req_stall  | req_rx_byte[7:0]
//  rsp     | out | rsp_valid/rsp_stall  | rsp_field_index, rsp_field_value, rsp_frame_bad,
//          |     |                      | rsp_good_frames, rsp_last_field
//
// A stream byte is taken whenever req_valid is high and req_stall is low. After a good
// checksum byte the 66 stored payload bytes are read back from the payload memory,
// each byte read, then assembled, and the frame's 26 items are emitted; req is
// stalled during this readout, including any rsp stall.
// A bad checksum loads one error item directly; the checksum byte is held off while
// an earlier item still waits in the output register.
// Synchronous reset clears control state only; the payload memory needs no clearing.
module positioning_frame_decoder_unit
   import pfd_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [FIELD_W-1:0]        rsp_field_index,
   output logic signed [VALUE_W-1:0] rsp_field_value,
   output logic                      rsp_frame_bad,
   output logic [COUNT_W-1:0]        rsp_good_frames,
   output logic                      rsp_last_field
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(STORE_FIRST);
   localparam logic [POS_W-1:0] POS_STOP  = POS_W'(STORE_LAST);

   state_type                state_ff, state_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [7:0]               sum_ff, sum_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   logic [STORE_AW-1:0]      rd_addr_ff, rd_addr_in;
   logic [FIELD_W-1:0]       fld_ff, fld_in;
   logic [1:0]               bsel_ff, bsel_in;
   logic [15:0]              acc_ff, acc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_bad_ff, rsp_bad_in;
   logic [COUNT_W-1:0]       rsp_good_ff, rsp_good_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [7:0]               mem [STORE_DEPTH];
   logic [7:0]               rd_data_ff;
   logic                     rd_en;
   logic                     wr_en;
   logic [STORE_AW-1:0]      wr_addr;

   logic                     req_fire;
   logic                     rsp_free;
   logic                     pos_last;
   logic                     fld_wide;
   logic                     fld_done;

   assign pos_last  = (pos_ff == POS_LAST);
   assign req_stall = (state_ff == ST_READ) || (state_ff == ST_WAIT) ||
                      ((state_ff == ST_BODY) && pos_last && rsp_valid_ff);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign fld_wide  = (fld_ff < FIELD_W'(WIDE_FIELDS));
   assign fld_done  = fld_wide ? (bsel_ff == 2'd2) : (bsel_ff == 2'd1);

   assign wr_en   = req_fire && (state_ff == ST_BODY) && !pos_last &&
                    (pos_ff >= POS_FIRST) && (pos_ff <= POS_STOP);
   assign wr_addr = STORE_AW'(pos_ff - POS_FIRST);
   assign rd_en   = (state_ff == ST_READ);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rd_addr_in   = rd_addr_ff;
      fld_in       = fld_ff;
      bsel_in      = bsel_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_good_in  = rsp_good_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_HUNT: begin
            if (req_fire) begin
               state_in = (req_rx_byte == HDR0) ? ST_HDR1 : ST_HUNT;
               pos_in   = '0;
               sum_in   = '0;
            end
         end
         ST_HDR1: begin
            if (req_fire) begin
               if (req_rx_byte == HDR1) begin
                  state_in = ST_BODY;
                  pos_in   = POS_W'(2);
                  sum_in   = HDR0 + HDR1;
               end else if (req_rx_byte != HDR0) begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_BODY: begin
            if (req_fire) begin
               if (!pos_last) begin
                  sum_in = sum_ff + req_rx_byte;
                  pos_in = pos_ff + POS_W'(1);
               end else begin
                  pos_in = '0;
                  sum_in = '0;
                  if (req_rx_byte != sum_ff) begin
                     state_in     = ST_HUNT;
                     rsp_valid_in = 1'b1;
                     rsp_index_in = '0;
                     rsp_value_in = '0;
                     rsp_bad_in   = 1'b1;
                     rsp_good_in  = cnt_ff;
                     rsp_last_in  = 1'b1;
                  end else begin
                     state_in   = ST_READ;
                     cnt_in     = cnt_ff + COUNT_W'(1);
                     rd_addr_in = '0;
                     fld_in     = '0;
                     bsel_in    = '0;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!fld_done) begin
               unique case (bsel_ff)
                  2'd0:    acc_in[7:0]  = rd_data_ff;
                  default: acc_in[15:8] = rd_data_ff;
               endcase
               bsel_in    = bsel_ff + 2'd1;
               rd_addr_in = rd_addr_ff + STORE_AW'(1);
               state_in   = ST_READ;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = fld_ff;
               rsp_value_in = fld_wide ? {rd_data_ff, acc_ff}
                                       : {{8{rd_data_ff[7]}}, rd_data_ff, acc_ff[7:0]};
               rsp_bad_in   = 1'b0;
               rsp_good_in  = cnt_ff;
               rsp_last_in  = (fld_ff == FIELD_W'(NUM_FIELDS - 1));
               bsel_in      = '0;
               rd_addr_in   = rd_addr_ff + STORE_AW'(1);
               fld_in       = fld_ff + FIELD_W'(1);
               state_in     = (fld_ff == FIELD_W'(NUM_FIELDS - 1)) ? ST_HUNT : ST_READ;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         pos_ff       <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rd_addr_ff   <= '0;
         fld_ff       <= '0;
         bsel_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rd_addr_ff   <= rd_addr_in;
         fld_ff       <= fld_in;
         bsel_ff      <= bsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_good_ff  <= rsp_good_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_index = rsp_index_ff;
   assign rsp_field_value = signed'(rsp_value_ff);
   assign rsp_frame_bad   = rsp_bad_ff;
   assign rsp_good_frames = rsp_good_ff;
   assign rsp_last_field  = rsp_last_ff;

   a_no_req_while_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_WAIT) |-> req_stall)
      else $error("req taken during field readout");

   a_bad_item_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_last_ff && rsp_index_ff == '0))
      else $error("error item malformed");

   a_good_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bad_ff) |-> (rsp_good_ff == cnt_ff))
      else $error("field item carries stale frame count");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_en || rd_en) |-> (wr_en ? (wr_addr < STORE_AW'(STORE_DEPTH))
                                  : (rd_addr_ff < STORE_AW'(STORE_DEPTH))))
      else $error("payload store address out of range");

   a_last_ends_readout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff && rsp_last_in && !rsp_bad_in) |=>
         (state_ff == ST_HUNT))
      else $error("readout continues past last field");

endmodule

### test/tb_positioning_frame_decoder_unit.sv
// Testbench for positioning_frame_decoder_unit, checked against an in-bench frame decoder.
`timescale 1ns / 1ps

module tb_positioning_frame_decoder_unit
   import pfd_pkg::*;
();

   localparam int FRAME_LEN    = FRAME_BYTES_DEF;
   localparam int NARROW_FIRST = STORE_FIRST + 3 * WIDE_FIELDS;
   localparam int RANDOM_BYTES = 24;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic [FIELD_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      logic                      bad;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } field_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [FIELD_W-1:0]        rsp_field_index;
   logic signed [VALUE_W-1:0] rsp_field_value;
   logic                      rsp_frame_bad;
   logic [COUNT_W-1:0]        rsp_good_frames;
   logic                      rsp_last_field;

   // decoder state mirror
   state_type          sync_q = ST_HUNT;
   int unsigned        pos_q = 0;
   logic [7:0]         sum_q = '0;
   logic [7:0]         payload_q [STORE_DEPTH];
   logic [COUNT_W-1:0] good_count_q = '0;

   field_result_type pending_fields [$];
   logic [7:0]       frame_buf [FRAME_LEN];
   bit               no_idle = 1'b0;
   int               errors = 0;

   always #2 clock = ~clock;

   positioning_frame_decoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_frame_bad   (rsp_frame_bad),
      .rsp_good_frames (rsp_good_frames),
      .rsp_last_field  (rsp_last_field)
   );

   function automatic void decode_byte(input logic [7:0] b);
      field_result_type r;
      int unsigned      base;
      logic [15:0]      half;
      case (sync_q)
         ST_HDR1: begin
            if (b == HDR1) begin
               sync_q = ST_BODY;
               pos_q  = 2;
               sum_q  = HDR0 + HDR1;
            end else if (b != HDR0) begin
               sync_q = ST_HUNT;
            end
         end
         ST_BODY: begin
            if (pos_q < FRAME_LEN - 1) begin
               if (pos_q >= STORE_FIRST && pos_q <= STORE_LAST)
                  payload_q[pos_q - STORE_FIRST] = b;
               sum_q = sum_q + b;
               pos_q++;
            end else begin
               sync_q = ST_HUNT;
               pos_q  = 0;
               if (b != sum_q) begin
                  r = '{index: '0, value: '0, bad: 1'b1, count: good_count_q, last: 1'b1};
                  pending_fields.push_back(r);
               end else begin
                  good_count_q++;
                  for (int k = 0; k < NUM_FIELDS; k++) begin
                     if (k < WIDE_FIELDS) begin
                        base    = 3 * k;
                        r.value = {payload_q[base + 2], payload_q[base + 1], payload_q[base]};
                     end else begin
                        base    = NARROW_FIRST - STORE_FIRST + 2 * (k - WIDE_FIELDS);
                        half    = {payload_q[base + 1], payload_q[base]};
                        r.value = {{(VALUE_W - 16){half[15]}}, half};
                     end
                     r.index = FIELD_W'(k);
                     r.bad   = 1'b0;
                     r.count = good_count_q;
                     r.last  = (k == NUM_FIELDS - 1);
                     pending_fields.push_back(r);
                  end
               end
               sum_q = '0;
            end
         end
         default: begin
            sync_q = (b == HDR0) ? ST_HDR1 : ST_HUNT;
            pos_q  = 0;
            sum_q  = '0;
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      decode_byte(b);
   endtask

   function automatic logic [7:0] frame_sum(input int n);
      logic [7:0] s;
      s = '0;
      for (int i = 0; i < n; i++)
         s += frame_buf[i];
      return s;
   endfunction

   // header plus random body, sometimes with a header pair inside
   function automatic void new_frame();
      int at;
      frame_buf[0] = HDR0;
      frame_buf[1] = HDR1;
      for (int i = 2; i < FRAME_LEN; i++)
         frame_buf[i] = 8'($urandom);
      if ($urandom_range(3) == 0) begin
         at = $urandom_range(2, FRAME_LEN - 3);
         frame_buf[at]     = HDR0;
         frame_buf[at + 1] = HDR1;
      end
   endfunction

   function automatic void set_field(input int k, input logic [23:0] v);
      int base;
      if (k < WIDE_FIELDS) begin
         base = STORE_FIRST + 3 * k;
         frame_buf[base + 2] = v[23:16];
      end else begin
         base = NARROW_FIRST + 2 * (k - WIDE_FIELDS);
      end
      frame_buf[base]     = v[7:0];
      frame_buf[base + 1] = v[15:8];
   endfunction

   task automatic send_frame(input bit corrupt);
      logic [7:0] s;
      s = frame_sum(FRAME_LEN - 1);
      frame_buf[FRAME_LEN - 1] = corrupt ? s + 8'($urandom_range(1, 255)) : s;
      for (int i = 0; i < FRAME_LEN; i++)
         send_byte(frame_buf[i]);
   endtask

   task automatic test_noise_and_broken_header();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR1);
      send_byte(8'hAA);
      send_byte(HDR0);
      send_byte(8'h02);
      send_byte(HDR1);
      send_byte(HDR0);
      send_byte(HDR0);
      send_byte(HDR0);
      // repeated first header byte stays matched, frame starts here
      new_frame();
      frame_buf[FRAME_LEN - 1] = frame_sum(FRAME_LEN - 1);
      for (int i = 1; i < FRAME_LEN; i++)
         send_byte(frame_buf[i]);
   endtask

   // extreme field values, checksum byte 0xFF, no idling on either side
   task automatic test_field_extremes();
      logic [23:0] wide_ext [4]   = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
      logic [15:0] narrow_ext [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      new_frame();
      for (int k = 0; k < NUM_FIELDS; k++) begin
         if (k < WIDE_FIELDS)
            set_field(k, wide_ext[k % 4]);
         else
            set_field(k, {8'h00, narrow_ext[k % 4]});
      end
      frame_buf[STORE_LAST + 1] = HDR0;
      frame_buf[STORE_LAST + 2] = HDR1;
      frame_buf[FRAME_LEN - 2]  = 8'hFF - frame_sum(FRAME_LEN - 2);
      no_idle = 1'b1;
      send_frame(1'b0);
      while (pending_fields.size() != 0)
         @(posedge clock);
      no_idle = 1'b0;
   endtask

   task automatic test_bad_checksum();
      new_frame();
      send_frame(1'b1);
   endtask

   task automatic test_random_traffic();
      int sent;
      int n;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(99) < 60) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom));
            sent += n;
         end else begin
            send_byte(HDR0);
            n = $urandom_range(2, 255);
            send_byte((n == HDR0) ? 8'hAA : 8'(n));
            sent += 2;
         end
      end
   endtask

   always @(posedge clock) begin
      field_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_fields.size() == 0) begin
               $error("unexpected item: field_index %0d", rsp_field_index);
               errors++;
            end else begin
               want = pending_fields.pop_front();
               if (rsp_field_index !== want.index) begin
                  $error("field_index: expected %0d, got %0d", want.index, rsp_field_index);
                  errors++;
               end
               if (rsp_field_value !== want.value) begin
                  $error("field_value: expected %0d, got %0d", want.value, rsp_field_value);
                  errors++;
               end
               if (rsp_frame_bad !== want.bad) begin
                  $error("frame_bad: expected %0d, got %0d", want.bad, rsp_frame_bad);
                  errors++;
               end
               if (rsp_good_frames !== want.count) begin
                  $error("good_frames: expected %0d, got %0d", want.count, rsp_good_frames);
                  errors++;
               end
               if (rsp_last_field !== want.last) begin
                  $error("last_field: expected %0d, got %0d", want.last, rsp_last_field);
                  errors++;
               end
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < 26);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_noise_and_broken_header();
      test_field_extremes();
      test_bad_checksum();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_fields.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
hdl/pfd_pkg.sv
hdl/positioning_frame_decoder_unit.sv
test/tb_positioning_frame_decoder_unit.sv
